### design/gbsg_pkg.sv
// Shared constants, types and the arctangent table of the goal bearing spin gate.
package gbsg_pkg;

    localparam int DEF_CORDIC_STAGES  = 16;
    localparam int DEF_POSITION_WIDTH = 24;

    localparam int QUAT_W  = 16;
    localparam int PROD_W  = 32;
    localparam int YAW_W   = 34;
    localparam int ZW      = 20;
    localparam int DELTA_W = ZW + 1;
    localparam int ANGLE_W = 16;
    localparam int REASON_W = 2;
    localparam int DIST_W  = 23;
    localparam int SPIN_W  = 15;
    localparam int LIMSQ_W = 2 * DIST_W;
    localparam int CFG_W   = 23;
    localparam int IDX_W   = 2;
    localparam int TAB_LEN = 24;

    localparam logic signed [ZW-1:0] ANG_PI      = 20'sd205887;
    localparam logic signed [ZW-1:0] ANG_HALF_PI = 20'sd102944;
    localparam logic signed [DELTA_W-1:0] ANG_PI_D     = 21'sd205887;
    localparam logic signed [DELTA_W-1:0] ANG_TWO_PI_D = 21'sd411774;

    localparam logic [IDX_W-1:0] REG_MIN_FACE = 2'd0;
    localparam logic [IDX_W-1:0] REG_MIN_SPIN = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAX_SPIN = 2'd2;

    localparam logic [DIST_W-1:0] RST_MIN_FACE = 23'd512;
    localparam logic [SPIN_W-1:0] RST_MIN_SPIN = 15'd1229;
    localparam logic [SPIN_W-1:0] RST_MAX_SPIN = 15'd19661;

    localparam logic [REASON_W-1:0] RSN_SPIN      = 2'd0;
    localparam logic [REASON_W-1:0] RSN_CLOSE     = 2'd1;
    localparam logic [REASON_W-1:0] RSN_TOO_SMALL = 2'd2;
    localparam logic [REASON_W-1:0] RSN_TOO_LARGE = 2'd3;

    typedef struct packed {
        logic [SPIN_W-1:0] lo_angle;
        logic [SPIN_W-1:0] hi_angle;
    } t_gate_cfg;

    // atan(2^-i) in 2^-16 rad
    function automatic logic signed [ZW-1:0] atan_tab(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0: a = 20'sd51472;
            1: a = 20'sd30386;
            2: a = 20'sd16055;
            3: a = 20'sd8150;
            4: a = 20'sd4091;
            5: a = 20'sd2047;
            6: a = 20'sd1024;
            7: a = 20'sd512;
            8: a = 20'sd256;
            9: a = 20'sd128;
            10: a = 20'sd64;
            11: a = 20'sd32;
            12: a = 20'sd16;
            13: a = 20'sd8;
            14: a = 20'sd4;
            15: a = 20'sd2;
            16: a = 20'sd1;
            default: a = 20'sd0;
        endcase
        return a;
    endfunction

endpackage

### design/gbsg_prep.sv
// Operand preparation: position difference and quaternion yaw operands.
module gbsg_prep #(
    parameter int PW = gbsg_pkg::DEF_POSITION_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [PW-1:0]                i_goal_x,
    input  logic signed [PW-1:0]                i_goal_y,
    input  logic signed [PW-1:0]                i_robot_x,
    input  logic signed [PW-1:0]                i_robot_y,
    input  logic signed [gbsg_pkg::QUAT_W-1:0]  i_quat_x,
    input  logic signed [gbsg_pkg::QUAT_W-1:0]  i_quat_y,
    input  logic signed [gbsg_pkg::QUAT_W-1:0]  i_quat_z,
    input  logic signed [gbsg_pkg::QUAT_W-1:0]  i_quat_w,
    output logic signed [PW:0]                  o_dx,
    output logic signed [PW:0]                  o_dy,
    output logic [PW:0]                         o_ax,
    output logic [PW:0]                         o_ay,
    output logic signed [gbsg_pkg::YAW_W-1:0]   o_num,
    output logic signed [gbsg_pkg::YAW_W-1:0]   o_den
);
    localparam int PRW = gbsg_pkg::PROD_W;
    localparam int YW  = gbsg_pkg::YAW_W;
    localparam logic signed [YW-1:0] ONE_Q30 = 34'sh0_4000_0000;

    logic signed [PW:0]    r_dx, r_dy;
    logic signed [PRW-1:0] r_wz, r_xy, r_yy, r_zz;
    logic signed [PW:0]    r_dx2, r_dy2;
    logic [PW:0]           r_ax, r_ay;
    logic signed [YW-1:0]  r_num, r_den;
    logic signed [PRW:0]   n_nsum, n_dsum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx <= (PW+1)'(i_goal_x) - (PW+1)'(i_robot_x);
            r_dy <= (PW+1)'(i_goal_y) - (PW+1)'(i_robot_y);
            r_wz <= i_quat_w * i_quat_z;
            r_xy <= i_quat_x * i_quat_y;
            r_yy <= i_quat_y * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;
        end
    end

    always_comb begin
        n_nsum = (PRW+1)'(r_wz) + (PRW+1)'(r_xy);
        n_dsum = (PRW+1)'(r_yy) + (PRW+1)'(r_zz);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx2 <= r_dx;
            r_dy2 <= r_dy;
            r_ax  <= r_dx[PW] ? (PW+1)'(-r_dx) : (PW+1)'(r_dx);
            r_ay  <= r_dy[PW] ? (PW+1)'(-r_dy) : (PW+1)'(r_dy);
            r_num <= {n_nsum, 1'b0};
            r_den <= ONE_Q30 - {n_dsum, 1'b0};
        end
    end

    assign o_dx  = r_dx2;
    assign o_dy  = r_dy2;
    assign o_ax  = r_ax;
    assign o_ay  = r_ay;
    assign o_num = r_num;
    assign o_den = r_den;
endmodule

### design/gbsg_cordic.sv
// Pipelined vectoring CORDIC: atan2(y, x) in 2^-16 rad, one stage per iteration.
module gbsg_cordic #(
    parameter int IW     = gbsg_pkg::YAW_W,
    parameter int STAGES = gbsg_pkg::DEF_CORDIC_STAGES
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [IW-1:0]            i_x,
    input  logic signed [IW-1:0]            i_y,
    output logic signed [gbsg_pkg::ZW-1:0]  o_z
);
    localparam int DW = IW + 3;
    localparam int ZW = gbsg_pkg::ZW;

    logic signed [DW-1:0] r_x [0:STAGES];
    logic signed [DW-1:0] r_y [0:STAGES];
    logic signed [ZW-1:0] r_z [0:STAGES];
    logic                 r_zero [0:STAGES];
    logic signed [DW-1:0] n_xe, n_ye;

    assign n_xe = DW'(i_x);
    assign n_ye = DW'(i_y);

    // quarter turn into the right half plane
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (!i_x[IW-1]) begin
                r_x[0] <= n_xe;
                r_y[0] <= n_ye;
                r_z[0] <= '0;
            end else if (!i_y[IW-1]) begin
                r_x[0] <= n_ye;
                r_y[0] <= -n_xe;
                r_z[0] <= gbsg_pkg::ANG_HALF_PI;
            end else begin
                r_x[0] <= -n_ye;
                r_y[0] <= n_xe;
                r_z[0] <= -gbsg_pkg::ANG_HALF_PI;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        localparam logic signed [ZW-1:0] A = gbsg_pkg::atan_tab(i);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (!r_y[i][DW-1]) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + A;
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - A;
                end
            end
        end
    end

    assign o_z = r_zero[STAGES] ? '0 : r_z[STAGES];
endmodule

### design/gbsg_dist.sv
// Minimum distance check by squared distance, delayed to match the CORDIC latency.
module gbsg_dist #(
    parameter int PW    = gbsg_pkg::DEF_POSITION_WIDTH,
    parameter int DELAY = gbsg_pkg::DEF_CORDIC_STAGES + 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [PW:0]                         i_ax,
    input  logic [PW:0]                         i_ay,
    input  logic [gbsg_pkg::DIST_W-1:0]         i_lim,
    input  logic [gbsg_pkg::LIMSQ_W-1:0]        i_lim_sq,
    output logic                                o_valid,
    output logic                                o_close
);
    localparam int AW  = PW + 1;
    localparam int LW  = gbsg_pkg::DIST_W;
    localparam int SQW = (AW < LW) ? AW : LW;
    localparam int CMW = (AW > LW) ? AW : LW;
    localparam int SW  = gbsg_pkg::LIMSQ_W + 1;

    logic                r_v [0:DELAY-1];
    logic                r_c [1:DELAY-1];
    logic                r_far;
    logic [2*SQW-1:0]    r_sx, r_sy;
    logic [SW-1:0]       n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DELAY; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < DELAY; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // squares only matter when both offsets are below the limit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_far <= (CMW'(i_ax) >= CMW'(i_lim)) || (CMW'(i_ay) >= CMW'(i_lim));
            r_sx  <= i_ax[SQW-1:0] * i_ax[SQW-1:0];
            r_sy  <= i_ay[SQW-1:0] * i_ay[SQW-1:0];
        end
    end

    assign n_sum = SW'(r_sx) + SW'(r_sy);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c[1] <= !r_far && (n_sum < SW'(i_lim_sq));
            for (int k = 2; k < DELAY; k++) begin
                r_c[k] <= r_c[k-1];
            end
        end
    end

    assign o_valid = r_v[DELAY-1];
    assign o_close = r_c[DELAY-1];
endmodule

### design/gbsg_gate.sv
// Angle wrap, rounding to 2^-13 rad and spin gating with the result register.
module gbsg_gate (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic                                i_close,
    input  logic signed [gbsg_pkg::ZW-1:0]      i_z_bear,
    input  logic signed [gbsg_pkg::ZW-1:0]      i_z_yaw,
    input  gbsg_pkg::t_gate_cfg                 i_cfg,
    output logic                                o_valid,
    output logic                                o_spin_enable,
    output logic signed [gbsg_pkg::ANGLE_W-1:0] o_spin_angle,
    output logic [gbsg_pkg::REASON_W-1:0]       o_gate_reason
);
    localparam int DLW = gbsg_pkg::DELTA_W;
    localparam int AGW = gbsg_pkg::ANGLE_W;
    localparam int SPW = gbsg_pkg::SPIN_W;

    logic [2:0]             r_v;
    logic [1:0]             r_close;
    logic signed [DLW-1:0]  r_d;
    logic signed [AGW-1:0]  r_ang;
    logic [SPW-1:0]         r_mag;
    logic                   r_en_out;
    logic signed [AGW-1:0]  r_ang_out;
    logic [1:0]             r_rsn_out;
    logic signed [DLW-1:0]  n_d, n_dr;
    logic signed [AGW-1:0]  n_ang;
    logic [1:0]             n_rsn;

    always_comb begin
        n_d = DLW'(i_z_bear) - DLW'(i_z_yaw);
        for (int k = 0; k < 2; k++) begin
            if (n_d > gbsg_pkg::ANG_PI_D) begin
                n_d = n_d - gbsg_pkg::ANG_TWO_PI_D;
            end else if (n_d <= -gbsg_pkg::ANG_PI_D) begin
                n_d = n_d + gbsg_pkg::ANG_TWO_PI_D;
            end
        end
        n_dr  = (r_d + DLW'(4)) >>> 3;
        n_ang = AGW'(n_dr);
        if (r_close[1]) begin
            n_rsn = gbsg_pkg::RSN_CLOSE;
        end else if (r_mag < i_cfg.lo_angle) begin
            n_rsn = gbsg_pkg::RSN_TOO_SMALL;
        end else if (r_mag > i_cfg.hi_angle) begin
            n_rsn = gbsg_pkg::RSN_TOO_LARGE;
        end else begin
            n_rsn = gbsg_pkg::RSN_SPIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d        <= n_d;
            r_close[0] <= i_close;
            r_ang      <= n_ang;
            r_mag      <= n_ang[AGW-1] ? SPW'(-n_ang) : SPW'(n_ang);
            r_close[1] <= r_close[0];
            r_en_out   <= (n_rsn == gbsg_pkg::RSN_SPIN);
            r_ang_out  <= (n_rsn == gbsg_pkg::RSN_SPIN) ? r_ang : '0;
            r_rsn_out  <= n_rsn;
        end
    end

    assign o_valid       = r_v[2];
    assign o_spin_enable = r_en_out;
    assign o_spin_angle  = r_ang_out;
    assign o_gate_reason = r_rsn_out;
endmodule

### design/goal_bearing_spin_gate.sv
// Top level of the goal bearing spin gate.
// Takes one pose transaction per cycle while the pipeline is not stalled and
// returns one result per pose: two stages form the position difference and the
// quaternion yaw operands, two CORDIC vectoring units (bearing and yaw) run one
// pre-rotation plus one iteration per stage, and three stages wrap, round and
// gate the angle. The whole pipeline advances while the output register is
// empty or being taken; a stall holds every stage. The squared distance limit
// is registered and follows a write of the minimum face distance in the next cycle.
module goal_bearing_spin_gate #(
    parameter int CORDIC_STAGES  = gbsg_pkg::DEF_CORDIC_STAGES,
    parameter int POSITION_WIDTH = gbsg_pkg::DEF_POSITION_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // goal_x, goal_y, robot_x, robot_y, quat_x, quat_y, quat_z, quat_w, zero pad
    input  logic [((4*POSITION_WIDTH+64+7)/8)*8-1:0] i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // spin_enable, spin_angle, gate_reason, zero pad
    output logic [23:0]                         o_m_tdata,
    input  logic                                i_cfg_we,
    input  logic [gbsg_pkg::IDX_W-1:0]          i_cfg_idx,
    input  logic [gbsg_pkg::CFG_W-1:0]          i_cfg_data
);
    localparam int PW = POSITION_WIDTH;
    localparam int QW = gbsg_pkg::QUAT_W;
    localparam int QB = 4 * PW;

    logic [gbsg_pkg::DIST_W-1:0]  r_min_face;
    logic [gbsg_pkg::SPIN_W-1:0]  r_lo_angle, r_hi_angle;
    logic [gbsg_pkg::LIMSQ_W-1:0] r_lim_sq;
    logic [1:0]                   r_vp;
    logic                         w_en;
    logic signed [PW:0]           w_dx, w_dy;
    logic [PW:0]                  w_ax, w_ay;
    logic signed [gbsg_pkg::YAW_W-1:0] w_num, w_den;
    logic signed [gbsg_pkg::ZW-1:0]    w_zb, w_zy;
    logic                         w_dvalid, w_close;
    gbsg_pkg::t_gate_cfg          w_cfg;
    logic                         w_spin;
    logic signed [gbsg_pkg::ANGLE_W-1:0] w_angle;
    logic [gbsg_pkg::REASON_W-1:0] w_reason;

    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_face <= gbsg_pkg::RST_MIN_FACE;
            r_lo_angle <= gbsg_pkg::RST_MIN_SPIN;
            r_hi_angle <= gbsg_pkg::RST_MAX_SPIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gbsg_pkg::REG_MIN_FACE: r_min_face <= i_cfg_data;
                gbsg_pkg::REG_MIN_SPIN: r_lo_angle <= i_cfg_data[gbsg_pkg::SPIN_W-1:0];
                gbsg_pkg::REG_MAX_SPIN: r_hi_angle <= i_cfg_data[gbsg_pkg::SPIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim_sq <= r_min_face * r_min_face;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= '0;
        end else if (w_en) begin
            r_vp <= {r_vp[0], i_s_tvalid};
        end
    end

    assign w_cfg.lo_angle = r_lo_angle;
    assign w_cfg.hi_angle = r_hi_angle;

    gbsg_prep #(.PW(PW)) u_prep (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_goal_x  (i_s_tdata[PW-1:0]),
        .i_goal_y  (i_s_tdata[2*PW-1:PW]),
        .i_robot_x (i_s_tdata[3*PW-1:2*PW]),
        .i_robot_y (i_s_tdata[4*PW-1:3*PW]),
        .i_quat_x  (i_s_tdata[QB+QW-1:QB]),
        .i_quat_y  (i_s_tdata[QB+2*QW-1:QB+QW]),
        .i_quat_z  (i_s_tdata[QB+3*QW-1:QB+2*QW]),
        .i_quat_w  (i_s_tdata[QB+4*QW-1:QB+3*QW]),
        .o_dx      (w_dx),
        .o_dy      (w_dy),
        .o_ax      (w_ax),
        .o_ay      (w_ay),
        .o_num     (w_num),
        .o_den     (w_den)
    );

    gbsg_cordic #(.IW(PW + 1), .STAGES(CORDIC_STAGES)) u_cordic_bear (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (w_dx),
        .i_y   (w_dy),
        .o_z   (w_zb)
    );

    gbsg_cordic #(.IW(gbsg_pkg::YAW_W), .STAGES(CORDIC_STAGES)) u_cordic_yaw (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (w_den),
        .i_y   (w_num),
        .o_z   (w_zy)
    );

    gbsg_dist #(.PW(PW), .DELAY(CORDIC_STAGES + 1)) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_vp[1]),
        .i_ax     (w_ax),
        .i_ay     (w_ay),
        .i_lim    (r_min_face),
        .i_lim_sq (r_lim_sq),
        .o_valid  (w_dvalid),
        .o_close  (w_close)
    );

    gbsg_gate u_gate (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (w_dvalid),
        .i_close       (w_close),
        .i_z_bear      (w_zb),
        .i_z_yaw       (w_zy),
        .i_cfg         (w_cfg),
        .o_valid       (o_m_tvalid),
        .o_spin_enable (w_spin),
        .o_spin_angle  (w_angle),
        .o_gate_reason (w_reason)
    );

    assign o_m_tdata = {5'd0, w_reason, w_angle, w_spin};

`ifndef SYNTHESIS
    a_spin_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_spin == (w_reason == gbsg_pkg::RSN_SPIN)))
        else $error("spin flag disagrees with reason");
    a_gated_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !w_spin) |-> (w_angle == '0))
        else $error("gated result carries an angle");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while pipeline stalled");
`endif
endmodule

### tb/tb_goal_bearing_spin_gate.sv
// Testbench for the goal bearing spin gate: directed and random poses against a bit-exact predictor.
module tb_goal_bearing_spin_gate;

    localparam int PW     = gbsg_pkg::DEF_POSITION_WIDTH;
    localparam int STAGES = gbsg_pkg::DEF_CORDIC_STAGES;
    localparam int IN_W   = ((4*PW+64+7)/8)*8;
    localparam int AW     = gbsg_pkg::ANGLE_W;
    localparam int RW     = gbsg_pkg::REASON_W;
    localparam int IXW    = gbsg_pkg::IDX_W;
    localparam int CW     = gbsg_pkg::CFG_W;

    typedef struct packed {
        logic                spin_enable;
        logic signed [AW-1:0] spin_angle;
        logic [RW-1:0]       gate_reason;
    } t_spin_result;

    class spin_scoreboard;
        t_spin_result pending[$];
        int mismatches;
        int checked;
        int reason_seen[4];
        logic [gbsg_pkg::DIST_W-1:0] face_lim;
        logic [gbsg_pkg::SPIN_W-1:0] spin_lo;
        logic [gbsg_pkg::SPIN_W-1:0] spin_hi;

        function new();
            mismatches = 0;
            checked = 0;
            face_lim = gbsg_pkg::RST_MIN_FACE;
            spin_lo = gbsg_pkg::RST_MIN_SPIN;
            spin_hi = gbsg_pkg::RST_MAX_SPIN;
        endfunction

        function void set_reg(logic [IXW-1:0] idx, logic [CW-1:0] val);
            if (idx == gbsg_pkg::REG_MIN_FACE) face_lim = val[gbsg_pkg::DIST_W-1:0];
            else if (idx == gbsg_pkg::REG_MIN_SPIN) spin_lo = val[gbsg_pkg::SPIN_W-1:0];
            else if (idx == gbsg_pkg::REG_MAX_SPIN) spin_hi = val[gbsg_pkg::SPIN_W-1:0];
        endfunction

        static function longint floor_shift(longint v, int s);
            return v >>> s;
        endfunction

        static function longint heading(longint x, longint y);
            longint z, t, xs, ys, a;
            z = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; z = gbsg_pkg::ANG_HALF_PI;
                end else begin
                    x = -y; y = t; z = -gbsg_pkg::ANG_HALF_PI;
                end
            end
            for (int i = 0; i < STAGES; i++) begin
                a = (i < 17) ? (i == 16 ? 1 : longint'(atan_val(i))) : 0;
                xs = floor_shift(x, i);
                ys = floor_shift(y, i);
                if (y >= 0) begin
                    x = x + ys; y = y - xs; z += a;
                end else begin
                    x = x - ys; y = y + xs; z -= a;
                end
            end
            return z;
        endfunction

        static function int atan_val(int i);
            int t[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2, 1};
            return t[i];
        endfunction

        function void note_pose(logic [IN_W-1:0] d);
            longint gx, gy, rx, ry, qx, qy, qz, qw, dx, dy, num, den;
            longint delta, ang, mag, ax, ay, lim, pi_v;
            logic close;
            logic [RW-1:0] rsn;
            t_spin_result r;
            pi_v = longint'(gbsg_pkg::ANG_PI);
            gx = longint'($signed(d[0*PW +: PW]));
            gy = longint'($signed(d[1*PW +: PW]));
            rx = longint'($signed(d[2*PW +: PW]));
            ry = longint'($signed(d[3*PW +: PW]));
            qx = longint'($signed(d[4*PW +: 16]));
            qy = longint'($signed(d[4*PW+16 +: 16]));
            qz = longint'($signed(d[4*PW+32 +: 16]));
            qw = longint'($signed(d[4*PW+48 +: 16]));
            dx = gx - rx;
            dy = gy - ry;
            num = 2 * (qw * qz + qx * qy);
            den = (longint'(1) << 30) - 2 * (qy * qy + qz * qz);
            delta = heading(dx, dy) - heading(den, num);
            for (int k = 0; k < 2; k++) begin
                if (delta > pi_v) delta -= 2 * pi_v;
                else if (delta <= -pi_v) delta += 2 * pi_v;
            end
            ang = (delta + 4) >>> 3;
            mag = ang < 0 ? -ang : ang;
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            lim = longint'(face_lim);
            if (ax >= lim || ay >= lim) close = 1'b0;
            else close = (ax * ax + ay * ay) < lim * lim;
            if (close) rsn = gbsg_pkg::RSN_CLOSE;
            else if (mag < longint'(spin_lo)) rsn = gbsg_pkg::RSN_TOO_SMALL;
            else if (mag > longint'(spin_hi)) rsn = gbsg_pkg::RSN_TOO_LARGE;
            else rsn = gbsg_pkg::RSN_SPIN;
            r.spin_enable = (rsn == gbsg_pkg::RSN_SPIN);
            r.spin_angle = (rsn == gbsg_pkg::RSN_SPIN) ? ang[AW-1:0] : '0;
            r.gate_reason = rsn;
            pending.push_back(r);
        endfunction

        function void check_result(logic [23:0] d);
            t_spin_result got, exp_r;
            got.spin_enable = d[0];
            got.spin_angle = d[16:1];
            got.gate_reason = d[18:17];
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected result %h", d);
                return;
            end
            exp_r = pending.pop_front();
            reason_seen[exp_r.gate_reason]++;
            if (got !== exp_r || d[23:19] !== '0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d exp en=%0b ang=%0d rsn=%0d %s",
                             checked, exp_r.spin_enable, exp_r.spin_angle,
                             exp_r.gate_reason,
                             $sformatf("got en=%0b ang=%0d rsn=%0d pad=%h",
                                       got.spin_enable, got.spin_angle,
                                       got.gate_reason, d[23:19]));
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [IN_W-1:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;
    logic i_cfg_we = 1'b0;
    logic [IXW-1:0] i_cfg_idx = '0;
    logic [CW-1:0] i_cfg_data = '0;

    spin_scoreboard sb = new();
    bit calm = 1'b0;
    int poses_sent = 0;

    goal_bearing_spin_gate dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) i_m_tready <= 1'b0;
        else i_m_tready <= calm || ($urandom_range(99) >= 12);
    end

    task automatic write_reg(logic [IXW-1:0] idx, logic [CW-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (STAGES + 10) @(negedge i_clk);
    endtask

    // called at a falling edge; returns at a falling edge after acceptance
    task automatic send_pose(logic [IN_W-1:0] d);
        while (!calm && $urandom_range(99) < 12) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_pose(d);
        poses_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [IN_W-1:0] pack_pose(longint gx, longint gy, longint rx,
            longint ry, longint qx, longint qy, longint qz, longint qw);
        logic [IN_W-1:0] d;
        d = '0;
        d[0*PW +: PW] = gx[PW-1:0];
        d[1*PW +: PW] = gy[PW-1:0];
        d[2*PW +: PW] = rx[PW-1:0];
        d[3*PW +: PW] = ry[PW-1:0];
        d[4*PW +: 16] = qx[15:0];
        d[4*PW+16 +: 16] = qy[15:0];
        d[4*PW+32 +: 16] = qz[15:0];
        d[4*PW+48 +: 16] = qw[15:0];
        return d;
    endfunction

    function automatic logic [IN_W-1:0] random_pose();
        logic [IN_W-1:0] d;
        longint gx, gy, rx, ry, c, s;
        int mode;
        mode = $urandom_range(9);
        d = '0;
        for (int i = 0; i < IN_W / 32; i++)
            d[i*32 +: 32] = $urandom();
        if (mode < 6) begin
            // plausible pose: nearby goal, quaternion with small x and y parts
            rx = $signed(24'($urandom()));
            ry = $signed(24'($urandom()));
            rx = rx >>> $urandom_range(0, 8);
            ry = ry >>> $urandom_range(0, 8);
            gx = rx + $signed(14'($urandom())) * (mode < 2 ? 1 : 8);
            gy = ry + $signed(14'($urandom())) * (mode < 2 ? 1 : 8);
            c = $signed(16'($urandom()));
            s = (mode == 5) ? 0 : 32767 - (c < 0 ? -c : c);
            if ($urandom_range(1)) s = -s;
            d = pack_pose(gx, gy, rx, ry, $urandom_range(0, 40) - 20,
                          $urandom_range(0, 40) - 20, s, c);
        end
        return d;
    endfunction

    initial begin
        longint ext[4] = '{-8388608, 8388607, 0, 1};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: identity pose, coincident goal, face distance boundary, extremes, degenerate quaternion
        calm = 1'b1;
        send_pose(pack_pose(0, 0, 0, 0, 0, 0, 0, 32767));
        send_pose(pack_pose(100000, 0, 0, 0, 0, 0, 0, 32767));
        send_pose(pack_pose(0, 100000, 0, 0, 0, 0, 0, 32767));
        send_pose(pack_pose(-100000, 0, 0, 0, 0, 0, 0, 32767));
        send_pose(pack_pose(-100000, -1, 0, 0, 0, 0, 0, 32767));
        send_pose(pack_pose(-100000, 0, 0, 0, 0, 0, 32767, 0));
        send_pose(pack_pose(100, 100, 0, 0, 0, 0, 23170, 23170));
        send_pose(pack_pose(5000, 0, 0, 0, 0, 0, 0, 0));
        send_pose(pack_pose(8388607, 8388607, -8388608, -8388608, 0, 0, 0, 32767));
        send_pose(pack_pose(-8388608, -8388608, 8388607, 8388607,
                            -32768, -32768, -32768, -32768));
        send_pose(pack_pose(-8388608, 8388607, 8388607, -8388608,
                            32767, 32767, 32767, 32767));
        send_pose(pack_pose(511, 0, 0, 0, 0, 0, 0, 32767));
        send_pose(pack_pose(512, 0, 0, 0, 0, 0, 0, 32767));
        send_pose(pack_pose(362, 362, 0, 0, 0, 0, 0, 32767));
        send_pose(pack_pose(10000, 1500, 0, 0, 0, 0, 0, 32767));
        for (int i = 0; i < 4; i++)
            send_pose(pack_pose(ext[i], ext[3-i], ext[(i+1)%4], ext[(i+2)%4],
                                ext[i] >>> 8, -32768, 32767, ext[3-i] >>> 8));
        i_s_tvalid <= 1'b0;
        calm = 1'b0;
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: ;
                1: begin
                    write_reg(gbsg_pkg::REG_MIN_FACE, 23'h7FFFFF);
                    write_reg(gbsg_pkg::REG_MIN_SPIN, 0);
                    write_reg(gbsg_pkg::REG_MAX_SPIN, 25736);
                end
                2: begin
                    write_reg(gbsg_pkg::REG_MIN_FACE, 0);
                    write_reg(gbsg_pkg::REG_MIN_SPIN, 25736);
                    write_reg(gbsg_pkg::REG_MAX_SPIN, 0);
                end
                3: begin
                    write_reg(gbsg_pkg::REG_MIN_FACE, 2'd3);
                    write_reg(gbsg_pkg::REG_MIN_FACE, CW'($urandom_range(0, 20000)));
                    write_reg(gbsg_pkg::REG_MIN_SPIN, 15'h7FFF);
                    write_reg(gbsg_pkg::REG_MIN_SPIN, CW'($urandom_range(0, 3000)));
                    write_reg(gbsg_pkg::REG_MAX_SPIN, 15'h7FFF);
                    write_reg(gbsg_pkg::REG_MAX_SPIN, CW'($urandom_range(3000, 25736)));
                end
                4: begin
                    write_reg(3, 23'h123456);
                    write_reg(gbsg_pkg::REG_MIN_FACE, 512);
                    write_reg(gbsg_pkg::REG_MIN_SPIN, 1229);
                    write_reg(gbsg_pkg::REG_MAX_SPIN, 19661);
                    calm = 1'b1;
                end
                default: begin
                    calm = 1'b0;
                    write_reg(gbsg_pkg::REG_MIN_FACE, CW'($urandom_range(0, 100000)));
                end
            endcase
            for (int n = 0; n < 180; n++) send_pose(random_pose());
            i_s_tvalid <= 1'b0;
            drain();
        end

        drain();
        $display("Sent %0d poses; reasons spin/close/small/large: %0d/%0d/%0d/%0d",
                 poses_sent, sb.reason_seen[0], sb.reason_seen[1],
                 sb.reason_seen[2], sb.reason_seen[3]);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

### filelist.f
design/gbsg_pkg.sv
design/gbsg_prep.sv
design/gbsg_cordic.sv
design/gbsg_dist.sv
design/gbsg_gate.sv
design/goal_bearing_spin_gate.sv
tb/tb_goal_bearing_spin_gate.sv
